[hdl/rqst2d_pkg.sv]
// Shared types and constants for the 2D sparse table range query block.
// No dependencies.
`default_nettype none
package rqst2d_pkg;
    localparam int MAX_SIDE_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] OPC_WRITE = 2'd0;
    localparam logic [1:0] OPC_BUILD = 2'd1;
    localparam logic [1:0] OPC_QUERY = 2'd2;

    localparam logic [1:0] RED_MIN = 2'd0;
    localparam logic [1:0] RED_MAX = 2'd1;
    localparam logic [1:0] RED_AND = 2'd2;
    localparam logic [1:0] RED_OR  = 2'd3;

    localparam logic CFG_OP_KIND   = 1'b0;
    localparam logic CFG_SIDE_SIZE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_B_RD0,
        ST_B_RD1,
        ST_B_WR,
        ST_Q_CHECK,
        ST_Q_RD,
        ST_Q_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic do_write;
        logic build_init;
        logic build_rd0;
        logic build_rd1;
        logic build_wr;
        logic build_adv;
        logic q_init;
        logic q_rd;
        logic q_emit;
        logic set_built;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       write_ok;
        logic       build_last;
        logic       build_skip;
        logic       q_bad;
        logic       q_rd_last;
    } stat_t;
endpackage
`default_nettype wire

[hdl/rqst2d_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rqst2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[hdl/rqst2d_ctrl.sv]
// Controller state machine for the 2D sparse table block.
// Depends on rqst2d_pkg.
`default_nettype none
module rqst2d_ctrl
    import rqst2d_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    output logic       busy,
    output ctrl_t      ctrl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                case (stat.opcode)
                    OPC_BUILD: state_next = stat.build_skip ? ST_IDLE : ST_B_RD0;
                    OPC_QUERY: state_next = ST_Q_CHECK;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_B_RD0:   state_next = ST_B_RD1;
            ST_B_RD1:   state_next = ST_B_WR;
            ST_B_WR:    state_next = stat.build_last ? ST_IDLE : ST_B_RD0;
            ST_Q_CHECK: state_next = stat.q_bad ? ST_Q_DONE : ST_Q_RD;
            ST_Q_RD:    state_next = stat.q_rd_last ? ST_Q_DONE : ST_Q_RD;
            ST_Q_DONE:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
                ctrl.load_item = start;
            ST_WRITE:
            begin
                ctrl.do_write   = (stat.opcode == OPC_WRITE) && stat.write_ok;
                ctrl.build_init = (stat.opcode == OPC_BUILD);
                ctrl.set_built  = (stat.opcode == OPC_BUILD) && stat.build_skip;
                ctrl.q_init     = (stat.opcode == OPC_QUERY);
            end
            ST_B_RD0:  ctrl.build_rd0 = 1'b1;
            ST_B_RD1:  ctrl.build_rd1 = 1'b1;
            ST_B_WR:
            begin
                ctrl.build_wr  = 1'b1;
                ctrl.build_adv = 1'b1;
                ctrl.set_built = stat.build_last;
            end
            ST_Q_RD:
                ctrl.q_rd = 1'b1;
            ST_Q_DONE:
                ctrl.q_emit = 1'b1;
            default: ctrl = '0;
        endcase
    end
endmodule
`default_nettype wire

[hdl/rqst2d_dp.sv]
// Datapath: item registers, table address generation, reduction, result.
// Depends on rqst2d_pkg and rqst2d_ram.
`default_nettype none
module rqst2d_dp
    import rqst2d_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctrl_t        ctrl,
    output stat_t             stat,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_index,
    input  wire logic         cfg_hit,
    input  wire logic [5:0]   cfg_data,
    input  wire logic [1:0]   opcode,
    input  wire logic [4:0]   cell_row,
    input  wire logic [4:0]   cell_col,
    input  wire logic [31:0]  cell_value,
    input  wire logic [4:0]   top_row,
    input  wire logic [4:0]   left_col,
    input  wire logic [4:0]   bottom_row,
    input  wire logic [4:0]   right_col,
    output logic              query_valid,
    output logic [31:0]       query_value,
    output logic              query_error
);
    localparam int LEVELS = $clog2(MAX_SIDE) + 1;
    localparam int CW     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SW     = $clog2(MAX_SIDE + 1);
    localparam int DEPTH  = MAX_SIDE * MAX_SIDE * LEVELS * LEVELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int VW     = VALUE_WIDTH;

    logic [1:0]   op_kind_reg;
    logic [5:0]   side_size_reg;
    logic         built_reg;
    logic [1:0]   opc_reg;
    logic [4:0]   a_reg, b_reg, c_reg, d_reg;
    logic [VW-1:0] val_reg;
    logic [SW-1:0] n;
    logic [LW-1:0] k_reg, l_reg, m_top;
    logic [CW-1:0] i_reg, j_reg;
    logic [VW-1:0] x_reg, acc_reg;
    logic [2:0]   qcnt_reg;
    logic [LW-1:0] s1_reg, s2_reg;
    logic [CW-1:0] xb_reg, yb_reg;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [VW-1:0] ram_wdata, ram_rdata;
    logic          rd_pend_reg;

    function automatic logic [AW-1:0] slot(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                          input logic [LW-1:0] k, input logic [LW-1:0] l);
        slot = AW'((((32'(r) * MAX_SIDE + 32'(c)) * LEVELS + 32'(k)) * LEVELS) + 32'(l));
    endfunction

    function automatic logic [VW-1:0] comb2(input logic [1:0] op, input logic [VW-1:0] p,
                                           input logic [VW-1:0] q);
        case (op)
            RED_MIN: comb2 = (p < q) ? p : q;
            RED_MAX: comb2 = (p > q) ? p : q;
            RED_AND: comb2 = p & q;
            default: comb2 = p | q;
        endcase
    endfunction

    function automatic logic [LW-1:0] flog2(input logic [5:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int t = 1; t < 6; t++)
            if (v >= 6'(1 << t) && t < LEVELS)
                r = LW'(t);
        flog2 = r;
    endfunction

    always_comb
    begin
        if (side_size_reg == 6'd0)
            n = SW'(1);
        else if (32'(side_size_reg) > MAX_SIDE)
            n = SW'(MAX_SIDE);
        else
            n = SW'(side_size_reg);
    end
    assign m_top = flog2(6'(n));

    logic [SW:0] i_end, j_end;
    logic        i_last, j_last, l_last, k_last;
    assign i_end  = (SW+1)'(n) - ((SW+1)'(1) << k_reg);
    assign j_end  = (SW+1)'(n) - ((SW+1)'(1) << l_reg);
    assign j_last = ((SW+1)'(j_reg) == j_end);
    assign i_last = ((SW+1)'(i_reg) == i_end);
    assign l_last = (l_reg == m_top);
    assign k_last = (k_reg == m_top);

    logic [CW-1:0] i2, j2;
    logic [LW-1:0] k2, l2;
    always_comb
    begin
        i2 = i_reg;
        j2 = j_reg;
        k2 = (k_reg == '0) ? k_reg : k_reg - LW'(1);
        l2 = (k_reg == '0) ? l_reg - LW'(1) : l_reg;
        if (k_reg == '0)
            j2 = CW'(32'(j_reg) + (1 << l2));
        else
            i2 = CW'(32'(i_reg) + (1 << k2));
    end

    assign stat.opcode     = opc_reg;
    assign stat.write_ok   = (32'(a_reg) < MAX_SIDE) && (32'(b_reg) < MAX_SIDE);
    assign stat.build_skip = (m_top == '0);
    assign stat.build_last = j_last && i_last && l_last && k_last;
    assign stat.q_bad      = !built_reg || (a_reg > c_reg) || (b_reg > d_reg)
                             || ((SW+1)'(c_reg) >= (SW+1)'(n)) || ((SW+1)'(d_reg) >= (SW+1)'(n));
    assign stat.q_rd_last  = (qcnt_reg == 3'd3);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = comb2(op_kind_reg, x_reg, ram_rdata);
        ram_addr  = slot(i_reg, j_reg, k_reg, l_reg);
        if (ctrl.do_write)
        begin
            ram_we    = 1'b1;
            ram_wdata = val_reg;
            ram_addr  = slot(CW'(a_reg), CW'(b_reg), '0, '0);
        end
        else if (ctrl.build_rd0)
            ram_addr = slot(i_reg, j_reg, k2, l2);
        else if (ctrl.build_rd1)
            ram_addr = slot(i2, j2, k2, l2);
        else if (ctrl.build_wr)
            ram_we = 1'b1;
        else if (ctrl.q_rd)
        begin
            case (qcnt_reg[1:0])
                2'd0:    ram_addr = slot(CW'(a_reg), CW'(b_reg), s1_reg, s2_reg);
                2'd1:    ram_addr = slot(xb_reg, CW'(b_reg), s1_reg, s2_reg);
                2'd2:    ram_addr = slot(CW'(a_reg), yb_reg, s1_reg, s2_reg);
                default: ram_addr = slot(xb_reg, yb_reg, s1_reg, s2_reg);
            endcase
        end
    end

    rqst2d_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_kind_reg   <= RED_MIN;
            side_size_reg <= 6'd32;
            built_reg     <= 1'b0;
            query_valid   <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            query_valid <= ctrl.q_emit;
            rd_pend_reg <= ctrl.q_rd;
            if (cfg_valid && cfg_hit)
            begin
                built_reg <= 1'b0;
                if (cfg_index == CFG_OP_KIND)
                    op_kind_reg <= cfg_data[1:0];
                else
                    side_size_reg <= cfg_data;
            end
            else if (ctrl.do_write)
                built_reg <= 1'b0;
            else if (ctrl.set_built)
                built_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            opc_reg <= opcode;
            if (opcode == OPC_WRITE)
            begin
                a_reg <= cell_row;
                b_reg <= cell_col;
            end
            else
            begin
                a_reg <= top_row;
                b_reg <= left_col;
            end
            c_reg   <= bottom_row;
            d_reg   <= right_col;
            val_reg <= VW'(cell_value);
        end
        if (ctrl.build_init)
        begin
            k_reg <= '0;
            l_reg <= LW'(1);
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (ctrl.build_adv)
        begin
            if (!j_last)
                j_reg <= j_reg + CW'(1);
            else
            begin
                j_reg <= '0;
                if (!i_last)
                    i_reg <= i_reg + CW'(1);
                else
                begin
                    i_reg <= '0;
                    if (!l_last)
                        l_reg <= l_reg + LW'(1);
                    else
                    begin
                        l_reg <= '0;
                        k_reg <= k_reg + LW'(1);
                    end
                end
            end
        end
        if (ctrl.build_rd1)
            x_reg <= ram_rdata;
        if (ctrl.q_init)
        begin
            s1_reg   <= flog2(6'(c_reg - a_reg) + 6'd1);
            s2_reg   <= flog2(6'(d_reg - b_reg) + 6'd1);
            qcnt_reg <= '0;
        end
        else if (ctrl.q_rd)
            qcnt_reg <= qcnt_reg + 3'd1;
        if (ctrl.q_rd && qcnt_reg == 3'd0)
        begin
            xb_reg <= CW'(6'(c_reg) + 6'd1 - (6'd1 << s1_reg));
            yb_reg <= CW'(6'(d_reg) + 6'd1 - (6'd1 << s2_reg));
        end
        if (rd_pend_reg)
            acc_reg <= (qcnt_reg == 3'd1) ? ram_rdata : comb2(op_kind_reg, acc_reg, ram_rdata);
        if (ctrl.q_emit)
        begin
            query_value <= rd_pend_reg ? 32'(comb2(op_kind_reg, acc_reg, ram_rdata)) : '0;
            query_error <= !rd_pend_reg;
        end
    end
endmodule
`default_nettype wire

[hdl/range_query_sparse_table_2d.sv]
// Top level of the 2D sparse table range query block.
// Depends on rqst2d_pkg, rqst2d_ctrl, rqst2d_dp, rqst2d_ram.
//
// Usage: an item is taken when start is high and busy is low. opcode 0 writes
// one cell, opcode 1 builds every block level, opcode 2 queries a rectangle,
// opcode 3 is dropped. A query gives one result: query_valid is high for one
// cycle with query_value and query_error; the receiver cannot stall.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// op_kind, index 1 is side_size. Write only while busy is low.
// Flow: a cell write or a dropped opcode keeps busy high in the write state
// after the transfer, so the next item waits for it. A query makes four
// reads on the single table port before its strobe, an error query none;
// the next item may transfer in the strobe cycle. A build keeps busy high
// while it makes two reads and one write per table entry on the single
// table port.
// Reset: clears the built mark and sets the configuration registers (op_kind 0,
// side_size 32); the table holds garbage until written and needs no clearing pass.
`default_nettype none
module range_query_sparse_table_2d
    import rqst2d_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [4:0]  cell_row,
    input  wire logic [4:0]  cell_col,
    input  wire logic [31:0] cell_value,
    input  wire logic [4:0]  top_row,
    input  wire logic [4:0]  left_col,
    input  wire logic [4:0]  bottom_row,
    input  wire logic [4:0]  right_col,
    output logic             query_valid,
    output logic [31:0]      query_value,
    output logic             query_error,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    rqst2d_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    rqst2d_dp #(.MAX_SIDE(MAX_SIDE), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index[0]),
        .cfg_hit     (cfg_index[31:1] == 31'd0),
        .cfg_data    (cfg_data[5:0]),
        .opcode      (opcode),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_value  (cell_value),
        .top_row     (top_row),
        .left_col    (left_col),
        .bottom_row  (bottom_row),
        .right_col   (right_col),
        .query_valid (query_valid),
        .query_value (query_value),
        .query_error (query_error)
    );
endmodule
`default_nettype wire

[test/range_query_sparse_table_2d_tb.sv]
// Self-checking testbench for range_query_sparse_table_2d: random cell loads, builds
// and rectangle queries under several reduction and grid settings, checked by a predictor.
// Depends on rqst2d_pkg and the range_query_sparse_table_2d RTL.
`default_nettype none
module range_query_sparse_table_2d_tb;
    import rqst2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OPC_UNUSED = 2'd3;
    localparam int LVL = 6;
    localparam int STALL_LIMIT = 800000;

    typedef enum logic {ENT_ITEM, ENT_CFG} ent_kind_t;

    typedef struct {
        ent_kind_t   kind;
        logic [1:0]  opc;
        logic [4:0]  crow, ccol, trow, lcol, brow, rcol;
        logic [31:0] cval;
        logic [31:0] idx, data;
    } pending_t;

    typedef struct {
        logic [31:0] value;
        logic        err;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start, busy, query_valid, query_error, cfg_valid, cfg_ready;
    logic [1:0] opcode;
    logic [4:0] cell_row, cell_col, top_row, left_col, bottom_row, right_col;
    logic [31:0] cell_value, query_value, cfg_index, cfg_data;

    pending_t pending_q[$];
    answer_t answers_q[$];
    int errors = 0;
    int loaded = 0;
    int settle = 0;
    int stall = 0;
    bit written[32][32];

    logic [31:0] grid_tbl [32][32][LVL][LVL];
    logic [1:0] red_kind = RED_MIN;
    logic [5:0] side_reg = 6'd32;
    bit built = 1'b0;

    always #4 clk = ~clk;

    range_query_sparse_table_2d u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .cell_row(cell_row), .cell_col(cell_col), .cell_value(cell_value),
        .top_row(top_row), .left_col(left_col), .bottom_row(bottom_row),
        .right_col(right_col), .query_valid(query_valid), .query_value(query_value),
        .query_error(query_error), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [31:0] reduce2(logic [31:0] a, logic [31:0] b);
        case (red_kind)
            RED_MIN: return (a < b) ? a : b;
            RED_MAX: return (a > b) ? a : b;
            RED_AND: return a & b;
            default: return a | b;
        endcase
    endfunction

    function automatic int grid_side();
        if (side_reg == 0) return 1;
        if (side_reg > 32) return 32;
        return int'(side_reg);
    endfunction

    function automatic int log2_floor(int v);
        int r;
        r = 0;
        while (v > 1)
        begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void build_levels();
        int n, m;
        n = grid_side();
        m = log2_floor(n) + 1;
        for (int k = 0; k < m; k++)
            for (int l = 0; l < m; l++)
                for (int i = 0; i + (1 << k) <= n; i++)
                    for (int j = 0; j + (1 << l) <= n; j++)
                    begin
                        if (k == 0 && l == 0)
                            continue;
                        if (k == 0)
                            grid_tbl[i][j][0][l] = reduce2(grid_tbl[i][j][0][l-1],
                                grid_tbl[i][j + (1 << (l-1))][0][l-1]);
                        else
                            grid_tbl[i][j][k][l] = reduce2(grid_tbl[i][j][k-1][l],
                                grid_tbl[i + (1 << (k-1))][j][k-1][l]);
                    end
        built = 1'b1;
    endfunction

    function automatic answer_t rect_answer(int x1, int y1, int x2, int y2);
        answer_t a;
        int n, s1, s2, xb, yb;
        n = grid_side();
        if (!built || x1 > x2 || y1 > y2 || x2 >= n || y2 >= n)
        begin
            a.value = '0;
            a.err = 1'b1;
            return a;
        end
        s1 = log2_floor(x2 - x1 + 1);
        s2 = log2_floor(y2 - y1 + 1);
        xb = x2 + 1 - (1 << s1);
        yb = y2 + 1 - (1 << s2);
        a.value = reduce2(grid_tbl[x1][y1][s1][s2], reduce2(grid_tbl[xb][y1][s1][s2],
            reduce2(grid_tbl[x1][yb][s1][s2], grid_tbl[xb][yb][s1][s2])));
        a.err = 1'b0;
        return a;
    endfunction

    function automatic pending_t rand_item(logic [1:0] opc);
        pending_t p;
        p.kind = ENT_ITEM;
        p.opc = opc;
        p.crow = 5'($urandom);
        p.ccol = 5'($urandom);
        p.cval = $urandom;
        p.trow = 5'($urandom);
        p.lcol = 5'($urandom);
        p.brow = 5'($urandom);
        p.rcol = 5'($urandom);
        p.idx = '0;
        p.data = '0;
        return p;
    endfunction

    function automatic logic [31:0] cell_pick(logic [1:0] rk);
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return (rk == RED_AND) ? ($urandom | $urandom | $urandom) : $urandom;
            3: return (rk == RED_OR) ? ($urandom & $urandom & $urandom) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_cfg(logic [31:0] idx, logic [31:0] data);
        pending_t p;
        p = rand_item(OPC_WRITE);
        p.kind = ENT_CFG;
        p.idx = idx;
        p.data = data;
        pending_q.push_back(p);
    endfunction

    function automatic void push_cell(int r, int c, logic [31:0] v);
        pending_t p;
        p = rand_item(OPC_WRITE);
        p.crow = 5'(r);
        p.ccol = 5'(c);
        p.cval = v;
        written[r][c] = 1'b1;
        pending_q.push_back(p);
    endfunction

    function automatic void push_query(int t, int l, int b, int r);
        pending_t p;
        p = rand_item(OPC_QUERY);
        p.trow = 5'(t);
        p.lcol = 5'(l);
        p.brow = 5'(b);
        p.rcol = 5'(r);
        pending_q.push_back(p);
    endfunction

    function automatic void fill_grid(int n, logic [1:0] rk);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                push_cell(r, c, cell_pick(rk));
    endfunction

    function automatic void push_valid_query(int n);
        int t, l;
        t = $urandom_range(0, n - 1);
        l = $urandom_range(0, n - 1);
        push_query(t, l, $urandom_range(t, n - 1), $urandom_range(l, n - 1));
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        pending_t p;
        bit hold_item, hold_cfg;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            opcode <= OPC_WRITE;
            cell_row <= '0;
            cell_col <= '0;
            cell_value <= '0;
            top_row <= '0;
            left_col <= '0;
            bottom_row <= '0;
            right_col <= '0;
            cfg_index <= '0;
            cfg_data <= '0;
            settle <= 0;
        end
        else
        begin
            hold_item = start && busy;
            hold_cfg = cfg_valid && !cfg_ready;
            if (!start && !cfg_valid && !busy && answers_q.size() == 0)
                settle <= settle + 1;
            else
                settle <= 0;
            if (!hold_item && !hold_cfg)
            begin
                if (pending_q.size() == 0)
                begin
                    start <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else if (pending_q[0].kind == ENT_CFG)
                begin
                    start <= 1'b0;
                    if (settle >= 10 && !start && !cfg_valid)
                    begin
                        p = pending_q.pop_front();
                        cfg_valid <= 1'b1;
                        cfg_index <= p.idx;
                        cfg_data <= p.data;
                    end
                    else
                        cfg_valid <= 1'b0;
                end
                else if (!(loaded >= 400 && loaded < 800) && $urandom_range(0, 99) < 16)
                begin
                    start <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else
                begin
                    p = pending_q.pop_front();
                    loaded <= loaded + 1;
                    cfg_valid <= 1'b0;
                    start <= 1'b1;
                    opcode <= p.opc;
                    cell_row <= p.crow;
                    cell_col <= p.ccol;
                    cell_value <= p.cval;
                    top_row <= p.trow;
                    left_col <= p.lcol;
                    bottom_row <= p.brow;
                    right_col <= p.rcol;
                end
            end
        end
    end

    // predictor, result check and watchdog
    always @(posedge clk)
    begin
        answer_t a;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                if (cfg_index == 0)
                begin
                    red_kind = cfg_data[1:0];
                    built = 1'b0;
                end
                else if (cfg_index == 1)
                begin
                    side_reg = cfg_data[5:0];
                    built = 1'b0;
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                case (opcode)
                    OPC_WRITE:
                    begin
                        grid_tbl[cell_row][cell_col][0][0] = cell_value;
                        built = 1'b0;
                    end
                    OPC_BUILD: build_levels();
                    OPC_QUERY: answers_q.push_back(rect_answer(int'(top_row),
                        int'(left_col), int'(bottom_row), int'(right_col)));
                    default: ;
                endcase
            end
            if (query_valid)
            begin
                moved = 1'b1;
                if (answers_q.size() == 0)
                begin
                    $error("unexpected result value=%h error=%b", query_value, query_error);
                    errors++;
                end
                else
                begin
                    a = answers_q.pop_front();
                    if (query_value !== a.value)
                    begin
                        $error("query_value expected %h actual %h", a.value, query_value);
                        errors++;
                    end
                    if (query_error !== a.err)
                    begin
                        $error("query_error expected %b actual %b", a.err, query_error);
                        errors++;
                    end
                end
            end
            stall = moved ? 0 : stall + 1;
            if (stall >= STALL_LIMIT)
            begin
                $display("range_query_sparse_table_2d verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n, raw;
        logic [1:0] rk;
        // directed: default grid of 32, unsigned min
        push_query(0, 0, 0, 0);
        pending_q.push_back(rand_item(OPC_UNUSED));
        push_cell(0, 0, 32'h0);
        push_cell(31, 31, 32'hFFFF_FFFF);
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 32; c++)
                if (!written[r][c])
                    push_cell(r, c, cell_pick(RED_MIN));
        push_query(0, 0, 31, 31);
        pending_q.push_back(rand_item(OPC_BUILD));
        push_query(0, 0, 31, 31);
        push_query(0, 0, 0, 0);
        push_query(31, 31, 31, 31);
        push_query(5, 0, 4, 31);
        push_query(0, 9, 31, 8);
        push_query(3, 7, 20, 30);
        push_query(0, 31, 31, 31);
        pending_q.push_back(rand_item(OPC_UNUSED));
        push_query(16, 16, 31, 31);
        // small grids, side zero and side above the storage
        push_cfg(1, 32'd0);
        push_cfg(0, 32'(RED_MAX));
        push_query(0, 0, 0, 0);
        pending_q.push_back(rand_item(OPC_BUILD));
        push_query(0, 0, 0, 0);
        push_query(0, 0, 1, 0);
        push_cfg(1, 32'd63);
        pending_q.push_back(rand_item(OPC_BUILD));
        push_query(2, 3, 31, 30);
        push_cfg(1, 32'hFFFF_FFC5);
        push_cfg(0, 32'hFFFF_FFFE);
        pending_q.push_back(rand_item(OPC_BUILD));
        push_query(0, 0, 4, 4);
        push_query(0, 0, 5, 4);
        for (int ph = 0; ph < 5; ph++)
        begin
            rk = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: raw = 0;
                1: raw = 1;
                2: raw = 2;
                3: raw = $urandom_range(33, 63);
                default: raw = $urandom_range(3, 12);
            endcase
            n = (raw == 0) ? 1 : (raw > 32 ? 32 : raw);
            if (n == 32)
                raw = 9;
            n = (raw == 0) ? 1 : (raw > 32 ? 32 : raw);
            if ($urandom_range(0, 1))
            begin
                push_cfg(0, {$urandom} & ~32'h3 | 32'(rk));
                push_cfg(1, {$urandom} & ~32'h3F | 32'(raw));
            end
            else
            begin
                push_cfg(1, 32'(raw));
                push_cfg(0, 32'(rk));
            end
            fill_grid(n, rk);
            pending_q.push_back(rand_item(OPC_BUILD));
            for (int q = 0; q < 40; q++)
            begin
                case ($urandom_range(0, 19))
                    0: pending_q.push_back(rand_item(OPC_QUERY));
                    1: pending_q.push_back(rand_item(OPC_UNUSED));
                    2:
                    begin
                        push_cell($urandom_range(0, 31), $urandom_range(0, 31), cell_pick(rk));
                        if ($urandom_range(0, 1))
                            pending_q.push_back(rand_item(OPC_BUILD));
                    end
                    3: push_query($urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 31));
                    default: push_valid_query(n);
                endcase
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0);
        do
            @(posedge clk);
        while (start || cfg_valid || busy || answers_q.size() != 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && answers_q.size() == 0)
            $display("range_query_sparse_table_2d verification clean");
        else
            $display("range_query_sparse_table_2d verification failed");
        $finish;
    end
endmodule
`default_nettype wire
